// ===== hw/rtl/u2u8_pkg.sv =====
// Shared types and constants for the UTF-16 to UTF-8 encoder.
package u2u8_pkg;

  localparam int unsigned MaxResults = 7;
  localparam int unsigned CntW       = 3;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_TERM = 2'd1;
  localparam logic [1:0] KIND_OVF  = 2'd2;

  localparam logic [7:0] LEAD2     = 8'hc0;
  localparam logic [7:0] LEAD3     = 8'he0;
  localparam logic [7:0] LEAD4     = 8'hf0;
  localparam logic [7:0] CONT_MARK = 8'h80;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        end_of_string;
  } u2u8_in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic [1:0]  result_kind;
    logic [15:0] byte_length;
    logic        last_of_item;
  } u2u8_out_t;

  // All results caused by one code unit, ready for the result buffer.
  typedef struct packed {
    logic [CntW-1:0]                 count;
    u2u8_out_t [MaxResults-1:0]      items;
  } u2u8_batch_t;

endpackage

// ===== hw/rtl/u2u8_encoder.sv =====
// String state and single-pass encoding of one code unit into its result batch.
module u2u8_encoder import u2u8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  u2u8_in_t    item,
  input  logic [15:0] capacity,
  output u2u8_batch_t batch
);

  logic [15:0] bytes_written_r, bytes_written_nxt;
  logic [9:0]  held_r, held_nxt;
  logic        high_pending_r, high_pending_nxt;
  logic        overflowed_r, overflowed_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_written_r <= '0;
      held_r          <= '0;
      high_pending_r  <= 1'b0;
      overflowed_r    <= 1'b0;
    end else if (take) begin
      bytes_written_r <= bytes_written_nxt;
      held_r          <= held_nxt;
      high_pending_r  <= high_pending_nxt;
      overflowed_r    <= overflowed_nxt;
    end
  end

  logic [15:0] cu;
  logic        eos, is_high, is_low, flush, flush_fit, main_fit, ok, tail_en;
  logic [1:0]  tail_kind;
  logic [15:0] held_val;
  logic [20:0] cp;
  logic [7:0]  flush_b [3];
  logic [7:0]  main_b  [4];
  logic [2:0]  flush_n, main_n, fc, mc, total;
  logic [15:0] new_len;

  assign cu       = item.code_unit;
  assign eos      = item.end_of_string;
  assign is_high  = (cu[15:10] == 6'b110110);
  assign is_low   = (cu[15:10] == 6'b110111);
  assign held_val = {6'b110110, held_r};
  assign cp       = {1'b0, held_r, cu[9:0]} + 21'h10000;

  // Held high surrogate that finds no partner goes out as three bytes.
  assign flush_b[0] = LEAD3 | {4'd0, held_val[15:12]};
  assign flush_b[1] = CONT_MARK | {2'd0, held_val[11:6]};
  assign flush_b[2] = CONT_MARK | {2'd0, held_val[5:0]};

  always_comb begin
    main_n    = 3'd0;
    main_b[0] = '0;
    main_b[1] = '0;
    main_b[2] = '0;
    main_b[3] = '0;
    if (is_high && !eos) begin
      main_n = 3'd0;
    end else if (is_low && high_pending_r) begin
      main_n    = 3'd4;
      main_b[0] = LEAD4 | {5'd0, cp[20:18]};
      main_b[1] = CONT_MARK | {2'd0, cp[17:12]};
      main_b[2] = CONT_MARK | {2'd0, cp[11:6]};
      main_b[3] = CONT_MARK | {2'd0, cp[5:0]};
    end else if (cu[15:7] == '0) begin
      main_n    = 3'd1;
      main_b[0] = cu[7:0];
    end else if (cu[15:11] == '0) begin
      main_n    = 3'd2;
      main_b[0] = LEAD2 | {3'd0, cu[10:6]};
      main_b[1] = CONT_MARK | {2'd0, cu[5:0]};
    end else begin
      main_n    = 3'd3;
      main_b[0] = LEAD3 | {4'd0, cu[15:12]};
      main_b[1] = CONT_MARK | {2'd0, cu[11:6]};
      main_b[2] = CONT_MARK | {2'd0, cu[5:0]};
    end
  end

  assign flush     = high_pending_r && !is_low;
  assign flush_n   = flush ? 3'd3 : 3'd0;
  assign flush_fit = ({1'b0, bytes_written_r} + 17'd3) < {1'b0, capacity};
  assign main_fit  = (main_n == 3'd0) ||
                     (({1'b0, bytes_written_r} + 17'(flush_n) + 17'(main_n))
                      < {1'b0, capacity});

  always_comb begin
    fc        = 3'd0;
    mc        = 3'd0;
    ok        = 1'b1;
    if (overflowed_r) begin
      ok = 1'b1;
    end else if (flush && !flush_fit) begin
      ok = 1'b0;
    end else begin
      fc = flush_n;
      if (!main_fit) begin
        ok = 1'b0;
      end else begin
        mc = main_n;
      end
    end
  end

  assign new_len   = bytes_written_r + 16'(fc) + 16'(mc);
  assign tail_en   = !overflowed_r && (!ok || eos);
  assign tail_kind = ok ? KIND_TERM : KIND_OVF;
  assign total     = fc + mc + (tail_en ? 3'd1 : 3'd0);

  always_comb begin
    bytes_written_nxt = bytes_written_r;
    held_nxt          = held_r;
    high_pending_nxt  = high_pending_r;
    overflowed_nxt    = overflowed_r;
    if (eos) begin
      bytes_written_nxt = '0;
      held_nxt          = '0;
      high_pending_nxt  = 1'b0;
      overflowed_nxt    = 1'b0;
    end else if (!overflowed_r) begin
      held_nxt         = '0;
      high_pending_nxt = 1'b0;
      if (!ok) begin
        overflowed_nxt = 1'b1;
      end else begin
        bytes_written_nxt = new_len;
        if (is_high) begin
          held_nxt         = cu[9:0];
          high_pending_nxt = 1'b1;
        end
      end
    end
  end

  // Lay out flush bytes, then the main group, then the overflow or terminator.
  always_comb begin
    logic [2:0] pos;
    logic [2:0] off;
    batch.count = total;
    for (int i = 0; i < MaxResults; i++) begin
      pos = 3'(i);
      off = pos - fc;
      batch.items[i] = '0;
      if (pos < fc) begin
        batch.items[i].out_byte = flush_b[pos[1:0]];
      end else if (pos < fc + mc) begin
        batch.items[i].out_byte = main_b[off[1:0]];
      end else if (tail_en && pos == fc + mc) begin
        batch.items[i].result_kind = tail_kind;
        batch.items[i].byte_length = ok ? new_len : 16'd0;
      end
      batch.items[i].result_kind  = (pos < fc + mc) ? KIND_DATA
                                                     : batch.items[i].result_kind;
      batch.items[i].last_of_item = (pos == total - 3'd1) && (total != 3'd0);
    end
  end

endmodule

// ===== hw/rtl/u2u8_emitter.sv =====
// Result buffer: holds one batch and shifts it out one result per transfer.
module u2u8_emitter import u2u8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  u2u8_batch_t batch,
  output logic        free,
  output logic        out_valid,
  input  logic        out_stall,
  output u2u8_out_t   out_data
);

  u2u8_out_t       buf_r [MaxResults];
  logic [CntW-1:0] cnt_r;
  logic            xfer;

  assign out_valid = (cnt_r != '0);
  assign out_data  = buf_r[0];
  assign xfer      = out_valid && !out_stall;
  assign free      = (cnt_r == '0) || (cnt_r == CntW'(1) && xfer);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= batch.count;
    end else if (xfer) begin
      cnt_r <= cnt_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MaxResults; i++) buf_r[i] <= batch.items[i];
    end else if (xfer) begin
      // advance the queue by one
      for (int i = 0; i < MaxResults - 1; i++) buf_r[i] <= buf_r[i+1];
    end
  end

endmodule

// ===== hw/rtl/utf16_to_utf8_encoder_top.sv =====
// UTF-16 to UTF-8 encoder: an input transfer is registered in the input stage, then
// loaded into the result buffer. A code unit yields zero to seven results, sent one
// per cycle from the result buffer while out_stall is low; the next unit is taken as
// the last result of the previous one leaves, so the byte-wide result channel sets the
// throughput. Synchronous active-low reset empties both stages, clears string state and
// sets the destination capacity to 65535.
module utf16_to_utf8_encoder_top import u2u8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  u2u8_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output u2u8_out_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0] cap_r;
  logic        in_vld_r;
  u2u8_in_t    in_item_r;
  logic        free, load;
  u2u8_batch_t batch;

  assign load     = in_vld_r && free;
  assign in_stall = in_vld_r && !free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= 16'hffff;
      in_vld_r <= 1'b0;
    end else begin
      if (cfg_wr_en) cap_r <= cfg_wr_data;
      if (in_valid && !in_stall) begin
        in_vld_r <= 1'b1;
      end else if (load) begin
        in_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_item_r <= in_data;
  end

  u2u8_encoder u_enc (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (load),
    .item     (in_item_r),
    .capacity (cap_r),
    .batch    (batch)
  );

  u2u8_emitter u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .batch     (batch),
    .free      (free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/utf16_to_utf8_encoder_checker.sv =====
// Checker for the UTF-16 to UTF-8 encoder: predicts every result and compares transfers.
`timescale 1ns / 1ps

module utf16_to_utf8_encoder_checker import u2u8_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  u2u8_in_t    in_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  u2u8_out_t   out_data,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output int          mismatches,
  output int          outstanding
);

  localparam logic [15:0] SURR_BASE     = 16'hd800;
  localparam logic [15:0] LOW_SURR_BASE = 16'hdc00;
  localparam logic [15:0] SURR_TOP      = 16'hdfff;
  localparam int          REPORT_LIMIT  = 10;

  logic [15:0] capacity;
  logic [15:0] written;
  logic [9:0]  held_high;
  logic        high_held;
  logic        dropping;

  u2u8_out_t   unit_bytes[$];
  u2u8_out_t   utf8_due_q[$];

  task automatic add_result(input logic [7:0] b, input logic [1:0] kind,
                            input logic [15:0] len);
    u2u8_out_t r;
    r.out_byte     = b;
    r.result_kind  = kind;
    r.byte_length  = len;
    r.last_of_item = 1'b0;
    unit_bytes.push_back(r);
  endtask

  task automatic clear_string();
    written   = '0;
    held_high = '0;
    high_held = 1'b0;
    dropping  = 1'b0;
  endtask

  // Write the group only if it leaves room for the terminator.
  task automatic write_group(input logic [31:0] grp, input int cnt, output bit fits);
    if (int'(written) + cnt >= int'(capacity)) begin
      add_result(8'h00, KIND_OVF, 16'h0000);
      fits = 1'b0;
    end else begin
      for (int k = 0; k < cnt; k++) add_result(grp[31-8*k -: 8], KIND_DATA, 16'h0000);
      written = written + 16'(cnt);
      fits = 1'b1;
    end
  endtask

  task automatic write_bmp(input logic [15:0] v, output bit fits);
    if (v < 16'h0080)
      write_group({v[7:0], 24'h0}, 1, fits);
    else if (v < 16'h0800)
      write_group({LEAD2 | {3'b0, v[10:6]}, CONT_MARK | {2'b0, v[5:0]}, 16'h0}, 2, fits);
    else
      write_group({LEAD3 | {4'b0, v[15:12]}, CONT_MARK | {2'b0, v[11:6]},
                   CONT_MARK | {2'b0, v[5:0]}, 8'h0}, 3, fits);
  endtask

  task automatic encode_unit(input logic [15:0] cu, input logic eos);
    bit          is_high;
    bit          is_low;
    bit          ok;
    logic [20:0] cp;
    u2u8_out_t   r;
    unit_bytes.delete();
    is_high = (cu >= SURR_BASE) && (cu < LOW_SURR_BASE);
    is_low  = (cu >= LOW_SURR_BASE) && (cu <= SURR_TOP);
    ok      = 1'b1;
    if (dropping) begin
      if (eos) clear_string();
    end else begin
      // flush a held high surrogate that gets no partner
      if (high_held && !is_low) begin
        write_bmp({6'b110110, held_high}, ok);
        high_held = 1'b0;
        held_high = '0;
      end
      if (ok) begin
        if (is_high && !eos) begin
          held_high = cu[9:0];
          high_held = 1'b1;
        end else if (is_low && high_held) begin
          cp = 21'h10000 + {1'b0, held_high, cu[9:0]};
          high_held = 1'b0;
          held_high = '0;
          write_group({LEAD4 | {5'b0, cp[20:18]}, CONT_MARK | {2'b0, cp[17:12]},
                       CONT_MARK | {2'b0, cp[11:6]}, CONT_MARK | {2'b0, cp[5:0]}}, 4, ok);
        end else begin
          write_bmp(cu, ok);
        end
      end
      if (!ok) begin
        if (eos) begin
          clear_string();
        end else begin
          high_held = 1'b0;
          held_high = '0;
          dropping  = 1'b1;
        end
      end else if (eos) begin
        add_result(8'h00, KIND_TERM, written);
        clear_string();
      end
    end
    for (int i = 0; i < unit_bytes.size(); i++) begin
      r = unit_bytes[i];
      r.last_of_item = (i == unit_bytes.size() - 1);
      utf8_due_q.push_back(r);
    end
  endtask

  task automatic check_result(input u2u8_out_t got);
    u2u8_out_t want;
    if (utf8_due_q.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("%0t: unexpected result byte %02h kind %0d len %0d last %0b", $realtime,
                 got.out_byte, got.result_kind, got.byte_length, got.last_of_item);
    end else begin
      want = utf8_due_q.pop_front();
      if (got.out_byte !== want.out_byte || got.result_kind !== want.result_kind ||
          got.byte_length !== want.byte_length || got.last_of_item !== want.last_of_item) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: mismatch exp byte %02h kind %0d len %0d last %0b, got byte %02h kind %0d len %0d last %0b",
                   $realtime, want.out_byte, want.result_kind, want.byte_length,
                   want.last_of_item, got.out_byte, got.result_kind, got.byte_length,
                   got.last_of_item);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      capacity = 16'hffff;
      clear_string();
      utf8_due_q.delete();
      mismatches = 0;
    end else begin
      if (cfg_wr_en) capacity = cfg_wr_data;
      // retire the result before taking a new unit on the same edge
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) encode_unit(in_data.code_unit, in_data.end_of_string);
    end
    outstanding = utf8_due_q.size();
  end

endmodule

// ===== tb/utf16_to_utf8_encoder_top_tb.sv =====
// Top of the UTF-16 to UTF-8 encoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module utf16_to_utf8_encoder_top_tb;
  import u2u8_pkg::*;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  u2u8_in_t    in_data     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  u2u8_out_t   out_data;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  int mismatch_count;
  int due_count;
  int units_sent    = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  always #5 clk = ~clk;

  utf16_to_utf8_encoder_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  utf16_to_utf8_encoder_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .mismatches  (mismatch_count),
    .outstanding (due_count)
  );

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_unit(input logic [15:0] cu, input logic eos);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{code_unit: cu, end_of_string: eos};
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    units_sent++;
  endtask

  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    // let a unit with no results finish inside the block
    repeat (8) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [15:0] cap);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_string(input int len);
    int          i;
    int unsigned pick;
    logic        last;
    i = 0;
    while (i < len) begin
      pick = $urandom_range(99);
      last = (i == len - 1);
      if (pick < 30) begin
        send_unit(16'($urandom_range(16'h0000, 16'h007f)), last);
      end else if (pick < 45) begin
        send_unit(16'($urandom_range(16'h0080, 16'h07ff)), last);
      end else if (pick < 60) begin
        if ($urandom_range(1)) send_unit(16'($urandom_range(16'h0800, 16'hd7ff)), last);
        else send_unit(16'($urandom_range(16'he000, 16'hffff)), last);
      end else if (pick < 82) begin
        // well-formed pair; a pair cut by the end mark leaves a lone high surrogate
        send_unit(16'($urandom_range(16'hd800, 16'hdbff)), last);
        if (!last) begin
          i++;
          send_unit(16'($urandom_range(16'hdc00, 16'hdfff)), i == len - 1);
        end
      end else if (pick < 88) begin
        send_unit(16'($urandom_range(16'hd800, 16'hdbff)), last);
      end else if (pick < 94) begin
        send_unit(16'($urandom_range(16'hdc00, 16'hdfff)), last);
      end else begin
        send_unit(16'($urandom_range(16'h0000, 16'hffff)), last);
      end
      i++;
    end
  endtask

  task automatic run_phase(input int idle_in, input int idle_out, input int n_units);
    int          goal;
    int unsigned pick;
    send_idle_pct = idle_in;
    stall_pct     = idle_out;
    goal          = units_sent + n_units;
    while (units_sent < goal) begin
      if ($urandom_range(99) < 15) begin
        wait_for_quiet();
        pick = $urandom_range(99);
        if (pick < 30)      set_capacity(16'($urandom_range(0, 12)));
        else if (pick < 70) set_capacity(16'($urandom_range(13, 64)));
        else if (pick < 85) set_capacity(16'hffff);
        else                set_capacity(16'($urandom_range(65, 65535)));
      end
      send_string($urandom_range(1, 12));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // encoding widths and surrogate handling at the reset capacity
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007f, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07ff, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hffff, 1'b1);
    send_unit(16'hd800, 1'b0);
    send_unit(16'hdc00, 1'b0);
    send_unit(16'hdbff, 1'b0);
    send_unit(16'hdfff, 1'b1);
    send_unit(16'hdc00, 1'b0);
    send_unit(16'hd800, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hd801, 1'b0);
    send_unit(16'hd802, 1'b0);
    send_unit(16'hdc05, 1'b0);
    send_unit(16'hdbff, 1'b1);

    // overflow, dropping until the end mark, and overflow on the end mark
    wait_for_quiet();
    set_capacity(16'h0000);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0042, 1'b0);
    send_unit(16'h0043, 1'b1);
    send_unit(16'h0041, 1'b1);
    wait_for_quiet();
    set_capacity(16'h0001);
    send_unit(16'h007f, 1'b1);
    wait_for_quiet();
    set_capacity(16'h0005);
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hd800, 1'b0);
    send_unit(16'h0042, 1'b1);
    wait_for_quiet();
    set_capacity(16'hffff);

    run_phase(20, 66, 112);
    run_phase(66, 20, 112);
    run_phase(0, 0, 112);

    wait_for_quiet();
    repeat (12) @(negedge clk);
    if (mismatch_count == 0 && due_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
